>>> rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // Request kinds carried on in_tuser
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  // Capacity register
  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Bit positions of the result flags on out_tuser
  localparam int unsigned OUT_HIT_BIT   = 0;
  localparam int unsigned OUT_EVICT_BIT = 1;
  localparam int unsigned OUT_USER_W    = 2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // load the request registers
    logic evaluate;  // register the compare and victim-select results
    logic commit;    // update the table and load the result register
  } lkvc_cmd_t;

endpackage

`default_nettype wire

>>> rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: accept, look up, update, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output lkvc_pkg::lkvc_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;
  logic   accept;

  always_comb begin
    commit        = (state_r == S_UPDATE) && (!out_valid_r || out_tready);
    in_tready     = (state_r == S_IDLE) || commit;
    accept        = in_tvalid && in_tready;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit) begin
          state_nxt = accept ? S_LOOKUP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign cmd.capture  = accept;
  assign cmd.evaluate = (state_r == S_LOOKUP);
  assign cmd.commit   = commit;

endmodule

`default_nettype wire

>>> rtl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry table, parallel key match, victim select and recency-rank update.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_datapath #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned VALUE_BITS  = 16,
  parameter int unsigned IN_DATA_W   = 32,
  parameter int unsigned OUT_DATA_W  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lkvc_pkg::lkvc_cmd_t               cmd,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0]     cfg_wr_data,
  input  wire logic                              in_tuser,
  input  wire logic [IN_DATA_W-1:0]              in_tdata,
  output logic [OUT_DATA_W-1:0]                  out_tdata,
  output logic [lkvc_pkg::OUT_USER_W-1:0]        out_tuser
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > lkvc_pkg::CAP_BITS) ? OCC_W
                                                               : lkvc_pkg::CAP_BITS;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  // Request registers
  logic                  req_store_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_val_r;

  // Configuration
  logic [lkvc_pkg::CAP_BITS-1:0] capacity_r;

  // Entry table
  logic [KEY_BITS-1:0]   key_r   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_r   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      rank_r  [MAX_ENTRIES];
  logic [IDX_W-1:0]      rank_nxt[MAX_ENTRIES];
  logic [OCC_W-1:0]      occ_r, occ_nxt;

  // Lookup results
  logic                  hit_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [IDX_W-1:0]      hit_rank_r;
  logic [VALUE_BITS-1:0] hit_val_r;
  logic [IDX_W-1:0]      victim_r;
  logic                  full_r;

  logic                  hit_c;
  logic [IDX_W-1:0]      hit_idx_c;
  logic [IDX_W-1:0]      lru_idx_c;
  logic [IDX_W-1:0]      free_idx_c;
  logic                  full_c;
  logic [CMP_W-1:0]      cap_cmp;
  logic [CMP_W-1:0]      limit_c;
  logic [OCC_W-1:0]      oldest_rank;

  // Result registers
  logic [VALUE_BITS-1:0]               rd_val_r;
  logic [lkvc_pkg::OUT_USER_W-1:0]     flags_r;

  // Match, oldest entry and first free entry; lowest index wins
  always_comb begin
    cap_cmp     = CMP_W'(capacity_r);
    limit_c     = cap_cmp;
    if (cap_cmp == '0) begin
      limit_c = CMP_W'(1);
    end else if (cap_cmp > MAX_CMP) begin
      limit_c = MAX_CMP;
    end
    full_c      = CMP_W'(occ_r) >= limit_c;
    oldest_rank = occ_r - OCC_W'(1);
    hit_c       = 1'b0;
    hit_idx_c   = '0;
    lru_idx_c   = '0;
    free_idx_c  = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == req_key_r) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (valid_r[i] && OCC_W'(rank_r[i]) == oldest_rank) begin
        lru_idx_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx_c = IDX_W'(i);
      end
    end
  end

  // Table bookkeeping applied at commit
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    if (cmd.commit) begin
      if (hit_r) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (valid_r[i] && IDX_W'(i) != hit_idx_r && rank_r[i] < hit_rank_r) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
        rank_nxt[hit_idx_r] = '0;
      end else if (req_store_r == lkvc_pkg::REQ_STORE) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (valid_r[i] && !(full_r && IDX_W'(i) == victim_r)) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
        valid_nxt[victim_r] = 1'b1;
        rank_nxt[victim_r]  = '0;
        if (!full_r) begin
          occ_nxt = occ_r + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkvc_pkg::CAP_RESET;
      valid_r    <= '0;
      occ_r      <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_store_r <= in_tuser;
      req_key_r   <= in_tdata[KEY_BITS-1:0];
      req_val_r   <= in_tdata[KEY_BITS +: VALUE_BITS];
    end
    if (cmd.evaluate) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      hit_rank_r <= rank_r[hit_idx_c];
      hit_val_r  <= val_r[hit_idx_c];
      full_r     <= full_c;
      victim_r   <= full_c ? lru_idx_c : free_idx_c;
    end
    if (cmd.commit) begin
      if (req_store_r == lkvc_pkg::REQ_STORE) begin
        if (hit_r) begin
          val_r[hit_idx_r] <= req_val_r;
        end else begin
          key_r[victim_r] <= req_key_r;
          val_r[victim_r] <= req_val_r;
        end
      end
      rd_val_r <= (hit_r && req_store_r == lkvc_pkg::REQ_LOOKUP) ? hit_val_r : '0;
      flags_r[lkvc_pkg::OUT_HIT_BIT]   <= hit_r;
      flags_r[lkvc_pkg::OUT_EVICT_BIT] <= !hit_r && full_r
                                          && req_store_r == lkvc_pkg::REQ_STORE;
    end
  end

  assign out_tdata = OUT_DATA_W'(rd_val_r);
  assign out_tuser = flags_r;

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Sequence: a request is captured when accepted, the lookup edge registers the
//   match, and the update edge loads the result and raises out_tvalid.
// Overlap: the match-then-rank-update sequence takes no request during lookup;
//   a new one enters at the update; a result held by out_tready stalls input.
// Reset: synchronous, active low; clears all entries, ranks and occupancy and
//   sets capacity to 16. No clearing pass, the block is ready right after.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Capacity register write
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_BITS-1:0]        cfg_wr_data,
  // Request channel
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // in_tdata: key, then value, zero padded to bytes
  input  wire logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: req_type (0 lookup, 1 store)
  input  wire logic                                 in_tuser,
  // Result channel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // out_tdata: read_value, zero padded to bytes
  output logic [((VALUE_BITS+7)/8)*8-1:0]           out_tdata,
  // out_tuser: hit, then evicted
  output logic [lkvc_pkg::OUT_USER_W-1:0]           out_tuser
);

  localparam int unsigned IN_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

  lkvc_pkg::lkvc_cmd_t cmd;

  // Sequence each transaction: capture, evaluate, commit
  lkvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Hold the table; match keys in parallel, pick the victim (first free entry
  // or the entry ranked oldest) and age the ranks at commit
  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .IN_DATA_W   (IN_DATA_W),
    .OUT_DATA_W  (OUT_DATA_W)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_checker #(
  parameter int unsigned VALUE_BITS = 16
) (
  input wire logic                                     clk,
  input wire logic                                     rst_n,
  input wire logic                                     in_tvalid,
  input wire logic                                     in_tready,
  input wire logic                                     out_tvalid,
  input wire logic                                     out_tready,
  input wire logic [((VALUE_BITS+7)/8)*8-1:0]          out_tdata,
  input wire logic [lkvc_pkg::OUT_USER_W-1:0]          out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A nonzero value only comes with a hit
  a_val_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[lkvc_pkg::OUT_HIT_BIT] |-> out_tdata == '0)
    else $error("read value without hit");

  // Hit and eviction exclude each other
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[lkvc_pkg::OUT_HIT_BIT] && out_tuser[lkvc_pkg::OUT_EVICT_BIT]))
    else $error("hit and evicted both set");

  // The lookup cycle after an accepted transaction takes no new request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted during lookup");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
